### src/plob_pkg.sv
package plob_pkg;

   // field widths
   localparam int LEVEL_W    = 6;
   localparam int QTY_W      = 31;
   localparam int IN_QTY_W   = 32;
   localparam int LEVELS_DEF = 64;

   localparam logic [QTY_W-1:0] QTY_MAX = '1;

   // request commands
   localparam logic [1:0] CMD_SET   = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_ORDER = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   // response kinds
   localparam logic [1:0] KIND_FILL  = 2'd0;
   localparam logic [1:0] KIND_ACK   = 2'd1;
   localparam logic [1:0] KIND_QUOTE = 2'd2;

   // book sides, also the memory select
   localparam logic SIDE_BID   = 1'b0;
   localparam logic SIDE_OFFER = 1'b1;

   // memory control from the sequencer
   typedef struct packed {
      logic rd_sel;
      logic wr_en;
      logic wr_sel;
   } mem_ctl_type;

endpackage

### src/price_level_order_book_matcher_top.sv
// Price-level order book with a limit order matcher. Bid and offer quantities
// live in two registered-read memories of LEVELS entries, both reading as zero
// after reset. One request is processed at a time: set and add write the level
// and acknowledge, a limit order walks the opposite levels toward its limit and
// rests the remainder, and a best query skips empty levels from the top of book.
// The walk rate is one memory read per cycle while the response channel is not
// stalled, with the write-back of a level overlapped with the read of the next.
// Fills come out one per touched level, the last one flagged and carrying the
// rested remainder; a stalled response channel holds the walk in place.
module price_level_order_book_matcher_top
   import plob_pkg::*;
#(
   parameter int LEVELS = LEVELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_cmd,
   input  logic                       req_side,
   input  logic [LEVEL_W-1:0]         req_level,
   input  logic signed [IN_QTY_W-1:0] req_quantity,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [LEVEL_W-1:0]         rsp_price_level,
   output logic [QTY_W-1:0]           rsp_fill_or_quote_qty,
   output logic [QTY_W-1:0]           rsp_rested_quantity,
   output logic                       rsp_found,
   output logic                       rsp_last
);

   localparam int AW = $clog2(LEVELS);

   mem_ctl_type      mem_ctl;
   logic [AW-1:0]    raddr;
   logic [AW-1:0]    waddr;
   logic [QTY_W-1:0] wdata;
   logic [QTY_W-1:0] bid_rdata;
   logic [QTY_W-1:0] offer_rdata;
   logic [QTY_W-1:0] rdata;
   logic             rsel_ff;

   plob_ctrl #(
      .LEVELS (LEVELS),
      .AW     (AW)
   ) u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_side              (req_side),
      .req_level             (req_level),
      .req_quantity          (req_quantity),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_kind              (rsp_kind),
      .rsp_price_level       (rsp_price_level),
      .rsp_fill_or_quote_qty (rsp_fill_or_quote_qty),
      .rsp_rested_quantity   (rsp_rested_quantity),
      .rsp_found             (rsp_found),
      .rsp_last              (rsp_last),
      .rdata                 (rdata),
      .mem_ctl               (mem_ctl),
      .raddr                 (raddr),
      .waddr                 (waddr),
      .wdata                 (wdata)
   );

   // bid side store
   plob_level_mem #(
      .DEPTH (LEVELS),
      .AW    (AW)
   ) u_bid_mem (
      .clock (clock),
      .reset (reset),
      .raddr (raddr),
      .wr_en (mem_ctl.wr_en && (mem_ctl.wr_sel == SIDE_BID)),
      .waddr (waddr),
      .wdata (wdata),
      .rdata (bid_rdata)
   );

   // offer side store
   plob_level_mem #(
      .DEPTH (LEVELS),
      .AW    (AW)
   ) u_offer_mem (
      .clock (clock),
      .reset (reset),
      .raddr (raddr),
      .wr_en (mem_ctl.wr_en && (mem_ctl.wr_sel == SIDE_OFFER)),
      .waddr (waddr),
      .wdata (wdata),
      .rdata (offer_rdata)
   );

   // read side select follows the read latency
   always_ff @(posedge clock) begin
      rsel_ff <= mem_ctl.rd_sel;
   end

   assign rdata = (rsel_ff == SIDE_OFFER) ? offer_rdata : bid_rdata;

endmodule

### src/plob_level_mem.sv
module plob_level_mem
   import plob_pkg::*;
#(
   parameter int DEPTH = LEVELS_DEF,
   parameter int AW    = $clog2(LEVELS_DEF)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [AW-1:0]    raddr,
   input  logic             wr_en,
   input  logic [AW-1:0]    waddr,
   input  logic [QTY_W-1:0] wdata,
   output logic [QTY_W-1:0] rdata
);

   logic [QTY_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [QTY_W-1:0] rdata_ff;
   logic             rvalid_ff;

   // per-entry valid bits, an unwritten level reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   // storage with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff  <= mem_ff[raddr];
      rvalid_ff <= valid_ff[raddr];
   end

   assign rdata = rvalid_ff ? rdata_ff : '0;

endmodule

### src/plob_ctrl.sv
module plob_ctrl
   import plob_pkg::*;
#(
   parameter int LEVELS = LEVELS_DEF,
   parameter int AW     = $clog2(LEVELS_DEF)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_cmd,
   input  logic                req_side,
   input  logic [LEVEL_W-1:0]  req_level,
   input  logic signed [IN_QTY_W-1:0] req_quantity,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [LEVEL_W-1:0]  rsp_price_level,
   output logic [QTY_W-1:0]    rsp_fill_or_quote_qty,
   output logic [QTY_W-1:0]    rsp_rested_quantity,
   output logic                rsp_found,
   output logic                rsp_last,
   input  logic [QTY_W-1:0]    rdata,
   output mem_ctl_type         mem_ctl,
   output logic [AW-1:0]       raddr,
   output logic [AW-1:0]       waddr,
   output logic [QTY_W-1:0]    wdata
);

   localparam logic [AW-1:0] LAST_IDX = AW'(LEVELS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACK,
      ST_SWEEP,
      ST_REST,
      ST_QUERY
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic                    side_ff, side_in;
   logic [LEVEL_W-1:0]      lvl_ff, lvl_in;
   logic                    lvl_ok_ff, lvl_ok_in;
   logic [IN_QTY_W-1:0]     qty_ff, qty_in;
   logic [AW-1:0]           p_ff, p_in;
   logic [QTY_W-1:0]        remain_ff, remain_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic                    sel_ff, sel_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [AW-1:0]           pend_lvl_ff, pend_lvl_in;
   logic [QTY_W-1:0]        pend_qty_ff, pend_qty_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_kind_ff, rsp_kind_in;
   logic [LEVEL_W-1:0]      rsp_lvl_ff, rsp_lvl_in;
   logic [QTY_W-1:0]        rsp_qty_ff, rsp_qty_in;
   logic [QTY_W-1:0]        rsp_rest_ff, rsp_rest_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    can_push;
   logic                    in_range;
   logic [QTY_W-1:0]        vol;
   logic [QTY_W-1:0]        remain_n;
   logic [QTY_W:0]          rest_sum;
   logic signed [QTY_W+1:0] add_sum;
   logic [QTY_W-1:0]        set_val;
   logic [QTY_W-1:0]        add_val;
   logic [QTY_W-1:0]        rest_val;
   logic                    wr_en;

   assign can_push  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign in_range  = {1'b0, req_level} < (LEVEL_W + 1)'(LEVELS);

   // level arithmetic with saturation
   assign vol      = (remain_ff < rdata) ? remain_ff : rdata;
   assign remain_n = remain_ff - vol;
   assign set_val  = qty_ff[IN_QTY_W-1] ? '0 : qty_ff[QTY_W-1:0];
   assign add_sum  = $signed({2'b00, rdata}) + $signed({qty_ff[IN_QTY_W-1], qty_ff});
   assign add_val  = add_sum[QTY_W+1] ? '0 :
                     (add_sum[QTY_W] ? QTY_MAX : add_sum[QTY_W-1:0]);
   assign rest_sum = {1'b0, rdata} + {1'b0, remain_ff};
   assign rest_val = rest_sum[QTY_W] ? QTY_MAX : rest_sum[QTY_W-1:0];

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      side_in       = side_ff;
      lvl_in        = lvl_ff;
      lvl_ok_in     = lvl_ok_ff;
      qty_in        = qty_ff;
      p_in          = p_ff;
      remain_in     = remain_ff;
      idx_in        = idx_ff;
      sel_in        = sel_ff;
      pend_valid_in = pend_valid_ff;
      pend_lvl_in   = pend_lvl_ff;
      pend_qty_in   = pend_qty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_lvl_in    = rsp_lvl_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_rest_in   = rsp_rest_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wdata         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               side_in   = req_side;
               lvl_in    = req_level;
               lvl_ok_in = in_range;
               qty_in    = req_quantity;
               unique case (req_cmd) inside
                  CMD_SET, CMD_ADD: begin
                     state_in = ST_ACK;
                     idx_in   = req_level[AW-1:0];
                     sel_in   = req_side;
                  end
                  CMD_ORDER: begin
                     state_in      = ST_SWEEP;
                     idx_in        = (req_side == SIDE_BID) ? '0 : LAST_IDX;
                     sel_in        = ~req_side;
                     p_in          = in_range ? req_level[AW-1:0] : LAST_IDX;
                     remain_in     = req_quantity[IN_QTY_W-1] ? '0 :
                                     req_quantity[QTY_W-1:0];
                     pend_valid_in = 1'b0;
                  end
                  CMD_QUERY: begin
                     state_in = ST_QUERY;
                     idx_in   = (req_side == SIDE_BID) ? LAST_IDX : '0;
                     sel_in   = req_side;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // set or add, then acknowledge
         ST_ACK: begin
            if (can_push) begin
               wr_en        = lvl_ok_ff;
               wdata        = (cmd_ff == CMD_SET) ? set_val : add_val;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_lvl_in   = lvl_ff;
               rsp_qty_in   = '0;
               rsp_rest_in  = '0;
               rsp_found_in = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         // one opposite level per cycle unless a fill is stalled, previous fill held until the next
         ST_SWEEP: begin
            if (!(vol != '0 && pend_valid_ff && !can_push)) begin
               if (vol != '0) begin
                  wr_en = 1'b1;
                  wdata = rdata - vol;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_FILL;
                     rsp_lvl_in   = LEVEL_W'(pend_lvl_ff);
                     rsp_qty_in   = pend_qty_ff;
                     rsp_rest_in  = '0;
                     rsp_found_in = 1'b0;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_lvl_in   = idx_ff;
                  pend_qty_in   = vol;
               end
               remain_in = remain_n;
               if (idx_ff == p_ff || remain_n == '0) begin
                  state_in = ST_REST;
                  idx_in   = p_ff;
                  sel_in   = ~sel_ff;
               end else if (side_ff == SIDE_BID) begin
                  idx_in = idx_ff + 1'b1;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end

         // rest the remainder and close the request
         ST_REST: begin
            if (can_push) begin
               wr_en         = (remain_ff != '0);
               wdata         = rest_val;
               rsp_valid_in  = 1'b1;
               rsp_rest_in   = remain_ff;
               rsp_found_in  = 1'b0;
               rsp_last_in   = 1'b1;
               if (pend_valid_ff) begin
                  rsp_kind_in = KIND_FILL;
                  rsp_lvl_in  = LEVEL_W'(pend_lvl_ff);
                  rsp_qty_in  = pend_qty_ff;
               end else begin
                  rsp_kind_in = KIND_ACK;
                  rsp_lvl_in  = LEVEL_W'(p_ff);
                  rsp_qty_in  = '0;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         // walk from the top of book inward
         ST_QUERY: begin
            if (rdata != '0 || idx_ff == (side_ff ? LAST_IDX : '0)) begin
               if (can_push) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_QUOTE;
                  rsp_found_in = (rdata != '0);
                  rsp_lvl_in   = (rdata != '0) ? LEVEL_W'(idx_ff) : '0;
                  rsp_qty_in   = rdata;
                  rsp_rest_in  = '0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (side_ff == SIDE_BID) begin
               idx_in = idx_ff - 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      side_ff      <= side_in;
      lvl_ff       <= lvl_in;
      lvl_ok_ff    <= lvl_ok_in;
      qty_ff       <= qty_in;
      p_ff         <= p_in;
      remain_ff    <= remain_in;
      idx_ff       <= idx_in;
      sel_ff       <= sel_in;
      pend_lvl_ff  <= pend_lvl_in;
      pend_qty_ff  <= pend_qty_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_lvl_ff   <= rsp_lvl_in;
      rsp_qty_ff   <= rsp_qty_in;
      rsp_rest_ff  <= rsp_rest_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // memory access, read address is the next index
   assign raddr          = idx_in;
   assign waddr          = idx_ff;
   assign mem_ctl.rd_sel = sel_in;
   assign mem_ctl.wr_en  = wr_en;
   assign mem_ctl.wr_sel = sel_ff;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = rsp_kind_ff;
   assign rsp_price_level       = rsp_lvl_ff;
   assign rsp_fill_or_quote_qty = rsp_qty_ff;
   assign rsp_rested_quantity   = rsp_rest_ff;
   assign rsp_found             = rsp_found_ff;
   assign rsp_last              = rsp_last_ff;

endmodule

### src/plob_checker.sv
module plob_checker
   import plob_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [1:0]                 req_cmd,
   input logic                       req_side,
   input logic [LEVEL_W-1:0]         req_level,
   input logic signed [IN_QTY_W-1:0] req_quantity,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_kind,
   input logic [LEVEL_W-1:0]         rsp_price_level,
   input logic [QTY_W-1:0]           rsp_fill_or_quote_qty,
   input logic [QTY_W-1:0]           rsp_rested_quantity,
   input logic                       rsp_found,
   input logic                       rsp_last
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_price_level) && $stable(rsp_fill_or_quote_qty)
         && $stable(rsp_rested_quantity) && $stable(rsp_last))
      else $error("response changed while stalled");

   // a fill always moves quantity and never reports a quote
   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FILL |-> rsp_fill_or_quote_qty != '0 && !rsp_found)
      else $error("empty fill");

   // only fills of an order sweep are non-final, and carry no remainder
   a_mid_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == KIND_FILL && rsp_rested_quantity == '0)
      else $error("non-final response that is not a plain fill");

   // quotes close their request and report no remainder
   a_quote: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_QUOTE |-> rsp_last && rsp_rested_quantity == '0
         && (rsp_found || rsp_fill_or_quote_qty == '0))
      else $error("malformed quote");

   // acknowledges carry no quantity
   a_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ACK |-> rsp_last && !rsp_found
         && rsp_fill_or_quote_qty == '0)
      else $error("malformed acknowledge");

endmodule

bind price_level_order_book_matcher_top plob_checker u_plob_checker (.*);

### tb/price_level_order_book_matcher_checker.sv
`timescale 1ns / 100ps

module price_level_order_book_matcher_checker
   import plob_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [1:0]                 req_cmd,
   input  logic                       req_side,
   input  logic [LEVEL_W-1:0]         req_level,
   input  logic signed [IN_QTY_W-1:0] req_quantity,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [1:0]                 rsp_kind,
   input  logic [LEVEL_W-1:0]         rsp_price_level,
   input  logic [QTY_W-1:0]           rsp_fill_or_quote_qty,
   input  logic [QTY_W-1:0]           rsp_rested_quantity,
   input  logic                       rsp_found,
   input  logic                       rsp_last,
   output int                         mismatch_count,
   output int                         pending_count,
   output int                         fill_count,
   output int                         quote_count
);

   typedef struct packed {
      logic [1:0]         kind;
      logic [LEVEL_W-1:0] price_level;
      logic [QTY_W-1:0]   qty;
      logic [QTY_W-1:0]   rested;
      logic               found;
      logic               last;
   } book_event_type;

   localparam int NLEV = LEVELS_DEF;

   logic [QTY_W-1:0] bid_book [NLEV];
   logic [QTY_W-1:0] offer_book [NLEV];
   book_event_type   expected_events [$];

   assign pending_count = expected_events.size();

   // clamp a wide signed value into a level quantity
   function automatic logic [QTY_W-1:0] clamp_qty(longint v);
      if (v < 0) return '0;
      if (v > longint'(QTY_MAX)) return QTY_MAX;
      return v[QTY_W-1:0];
   endfunction

   function automatic book_event_type make_event(logic [1:0] k, int lv, logic [QTY_W-1:0] q,
                                                 logic [QTY_W-1:0] r, logic f, logic l);
      book_event_type e;
      e.kind = k;
      e.price_level = lv[LEVEL_W-1:0];
      e.qty = q;
      e.rested = r;
      e.found = f;
      e.last = l;
      return e;
   endfunction

   // apply one request to the book model and queue its responses
   task automatic predict_request(logic [1:0] cmd, logic side, logic [LEVEL_W-1:0] lvl,
                                  logic signed [IN_QTY_W-1:0] qty);
      longint q;
      int limit;
      int n;
      int i;
      logic [QTY_W-1:0] remain;
      logic [QTY_W-1:0] opp;
      logic [QTY_W-1:0] vol;
      book_event_type fills [$];
      q = longint'(qty);
      if (cmd == CMD_SET || cmd == CMD_ADD) begin
         if (side == SIDE_BID)
            bid_book[lvl] = clamp_qty(cmd == CMD_SET ? q : longint'(bid_book[lvl]) + q);
         else
            offer_book[lvl] = clamp_qty(cmd == CMD_SET ? q : longint'(offer_book[lvl]) + q);
         expected_events.push_back(make_event(KIND_ACK, lvl, '0, '0, 1'b0, 1'b1));
      end else if (cmd == CMD_QUERY) begin
         n = -1;
         if (side == SIDE_BID) begin
            for (i = NLEV - 1; i >= 0 && n < 0; i--)
               if (bid_book[i] != 0) n = i;
         end else begin
            for (i = 0; i < NLEV && n < 0; i++)
               if (offer_book[i] != 0) n = i;
         end
         if (n < 0)
            expected_events.push_back(make_event(KIND_QUOTE, 0, '0, '0, 1'b0, 1'b1));
         else
            expected_events.push_back(make_event(KIND_QUOTE, n,
               side == SIDE_BID ? bid_book[n] : offer_book[n], '0, 1'b1, 1'b1));
      end else begin
         limit = lvl;
         remain = q > 0 ? clamp_qty(q) : '0;
         for (n = 0; n < NLEV; n++) begin
            i = (side == SIDE_BID) ? n : NLEV - 1 - n;
            if (remain == 0) break;
            if (side == SIDE_BID ? i > limit : i < limit) break;
            opp = (side == SIDE_BID) ? offer_book[i] : bid_book[i];
            vol = remain < opp ? remain : opp;
            if (vol != 0) begin
               if (side == SIDE_BID) offer_book[i] = opp - vol;
               else bid_book[i] = opp - vol;
               remain = remain - vol;
               fills.push_back(make_event(KIND_FILL, i, vol, '0, 1'b0, 1'b0));
               fill_count++;
            end
         end
         if (remain != 0) begin
            if (side == SIDE_BID)
               bid_book[limit] = clamp_qty(longint'(bid_book[limit]) + longint'(remain));
            else
               offer_book[limit] = clamp_qty(longint'(offer_book[limit]) + longint'(remain));
         end
         if (fills.size() == 0) begin
            expected_events.push_back(make_event(KIND_ACK, limit, '0, remain, 1'b0, 1'b1));
         end else begin
            fills[fills.size()-1].rested = remain;
            fills[fills.size()-1].last = 1'b1;
            foreach (fills[j]) expected_events.push_back(fills[j]);
         end
      end
   endtask

   // watch both channels at the rising edge
   always @(posedge clock) begin
      book_event_type want;
      book_event_type got;
      if (reset) begin
         for (int i = 0; i < NLEV; i++) begin
            bid_book[i] <= '0;
            offer_book[i] <= '0;
         end
         expected_events.delete();
         mismatch_count <= 0;
         fill_count <= 0;
         quote_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = make_event(rsp_kind, rsp_price_level, rsp_fill_or_quote_qty,
                             rsp_rested_quantity, rsp_found, rsp_last);
            if (expected_events.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected response %p", got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_events.pop_front();
               if (got.kind == KIND_QUOTE && got.found) quote_count <= quote_count + 1;
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display("response mismatch: expected %p, got %p", want, got);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            predict_request(req_cmd, req_side, req_level, req_quantity);
      end
   end

endmodule

### tb/price_level_order_book_matcher_top_tb.sv
`timescale 1ns / 100ps

module price_level_order_book_matcher_top_tb;
   import plob_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [1:0]                 req_cmd;
   logic                       req_side;
   logic [LEVEL_W-1:0]         req_level;
   logic signed [IN_QTY_W-1:0] req_quantity;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [1:0]                 rsp_kind;
   logic [LEVEL_W-1:0]         rsp_price_level;
   logic [QTY_W-1:0]           rsp_fill_or_quote_qty;
   logic [QTY_W-1:0]           rsp_rested_quantity;
   logic                       rsp_found;
   logic                       rsp_last;
   int                         mismatch_count;
   int                         pending_count;
   int                         fill_count;
   int                         quote_count;
   int                         idle_cycles;
   int                         request_count;
   int                         rsp_hold;

   price_level_order_book_matcher_top dut (.*);

   price_level_order_book_matcher_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // random gap length, mostly short
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // quantity with a bias toward small sizes and the edges
   function automatic logic signed [IN_QTY_W-1:0] pick_qty();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom;
         3: return -$signed({1'b0, 31'($urandom_range(0, 50))});
         default: return $urandom_range(0, 200);
      endcase
   endfunction

   // valid stays high after acceptance until the next gap or the end of a phase
   task automatic send_request(logic [1:0] cmd, logic side, int lvl,
                               logic signed [IN_QTY_W-1:0] qty);
      int g;
      g = gap_len();
      @(negedge clock);
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_side <= side;
      req_level <= lvl[LEVEL_W-1:0];
      req_quantity <= qty;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      request_count++;
   endtask

   // response side back-pressure, with an occasional long stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (request_count > 150 && request_count < 200) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_ready <= 1'b0;
         rsp_hold <= $urandom_range(10, 40);
      end else begin
         rsp_ready <= ($urandom_range(0, 99) < 65);
      end
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL price_level_order_book_matcher_top");
         $finish;
      end
   end

   initial begin
      int c;
      request_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_SET;
      req_side = SIDE_BID;
      req_level = '0;
      req_quantity = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty queries, extremes, zero and negative orders, sweeps
      send_request(CMD_QUERY, SIDE_BID, 0, 0);
      send_request(CMD_QUERY, SIDE_OFFER, 63, 0);
      send_request(CMD_SET, SIDE_BID, 63, 32'sh7fffffff);
      send_request(CMD_ADD, SIDE_BID, 63, 100);
      send_request(CMD_SET, SIDE_OFFER, 0, -5);
      send_request(CMD_SET, SIDE_OFFER, 0, 40);
      send_request(CMD_SET, SIDE_OFFER, 5, 30);
      send_request(CMD_ADD, SIDE_OFFER, 5, 32'sh80000000);
      send_request(CMD_ADD, SIDE_OFFER, 5, 25);
      send_request(CMD_SET, SIDE_BID, 10, 12);
      send_request(CMD_QUERY, SIDE_BID, 0, 0);
      send_request(CMD_QUERY, SIDE_OFFER, 0, 0);
      send_request(CMD_ORDER, SIDE_BID, 63, 50);
      send_request(CMD_ORDER, SIDE_BID, 3, 0);
      send_request(CMD_ORDER, SIDE_OFFER, 3, -7);
      send_request(CMD_ORDER, SIDE_OFFER, 0, 32'sh7fffffff);
      send_request(CMD_ORDER, SIDE_BID, 63, 32'sh7fffffff);
      send_request(CMD_ORDER, SIDE_BID, 0, 32'sh7fffffff);
      send_request(CMD_QUERY, SIDE_BID, 0, 0);
      send_request(CMD_ORDER, SIDE_OFFER, 63, 32'sh7fffffff);
      send_request(CMD_QUERY, SIDE_OFFER, 0, 0);
      @(negedge clock);
      req_valid <= 1'b0;

      // hold off until the book has drained its responses
      while (pending_count != 0) @(negedge clock);

      // random: interleave book building and crossing orders, with some noise
      repeat (300) begin
         c = $urandom_range(0, 99);
         if (c < 35)
            send_request($urandom_range(0, 1) ? CMD_SET : CMD_ADD, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 63), pick_qty());
         else if (c < 80)
            send_request(CMD_ORDER, 1'($urandom_range(0, 1)), $urandom_range(0, 63),
                         pick_qty());
         else
            send_request(CMD_QUERY, 1'($urandom_range(0, 1)), $urandom_range(0, 63),
                         $urandom);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      $display("ran %0d requests: %0d fills and %0d found quotes checked",
               request_count, fill_count, quote_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("PASS price_level_order_book_matcher_top");
      else
         $display("FAIL price_level_order_book_matcher_top");
      $finish;
   end

endmodule
